### hw/rtl/pipc_pkg.sv
// shared types and constants for the point-in-polycone block
`timescale 1ns / 1ps

package pipc_pkg;

  // coordinate width of every length field
  localparam int COORD_BITS = 20;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WEDGE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_END    = 3'd4;

  // item modes
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // wedge modes
  localparam logic [1:0] WM_FULL = 2'd0;
  localparam logic [1:0] WM_AND  = 2'd1;
  localparam logic [1:0] WM_OR   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_TOO_FEW = 2'd3;

  // input item
  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic signed [COORD_BITS-1:0] r_inner;
    logic signed [COORD_BITS-1:0] r_outer;
  } in_t;

  // result item
  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
  } out_t;

  // multiply operations run on the shared multiplier
  typedef enum logic [3:0] {
    MOP_X2,
    MOP_Y2,
    MOP_DSQ,
    MOP_LHS,
    MOP_ROA,
    MOP_ROB,
    MOP_NSQ_OUT,
    MOP_RIA,
    MOP_RIB,
    MOP_NSQ_IN
  } mop_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic wr;
    logic clr;
    logic rd;
    logic take_prev;
    logic mul_go;
    mop_e mul_op;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       add_bad;
    logic       full;
    logic       too_few;
    logic       span_ok;
    logic       wedge_ok;
    logic       seg_hit;
    logic       seg_last;
    logic       mul_done;
    logic       seg_in;
  } stat_t;

endpackage

### hw/rtl/pipc_mul.sv
// multi-cycle unsigned multiplier built from W by W partial products
`timescale 1ns / 1ps

module pipc_mul #(
  parameter int W = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           wide_i,
  input  logic [2*W-1:0] a_i,
  input  logic [2*W-1:0] b_i,
  output logic           done_o,
  output logic [4*W-1:0] prod_o
);

  localparam int MW = 2 * W;
  localparam int AW = 4 * W;

  logic [MW-1:0] a_q, b_q, pp_q;
  logic [AW-1:0] acc_q, pp_sh;
  logic [1:0]    step_q, last_q, sh_q, sh;
  logic          issue_q, ppv_q, done_q;
  logic [W-1:0]  op_a, op_b;

  // half select: step 1 is lo*hi, step 2 is hi*lo, step 3 hi*hi
  assign op_a = step_q[1] ? a_q[MW-1:W] : a_q[W-1:0];
  assign op_b = step_q[0] ? b_q[MW-1:W] : b_q[W-1:0];
  assign sh   = {step_q[1] & step_q[0], step_q[1] ^ step_q[0]};

  // align partial product
  always_comb begin
    case (sh_q)
      2'd0:    pp_sh = AW'(pp_q);
      2'd1:    pp_sh = AW'(pp_q) << W;
      default: pp_sh = AW'(pp_q) << MW;
    endcase
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      ppv_q   <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= 2'd0;
      last_q  <= 2'd0;
    end else begin
      done_q <= ppv_q && !issue_q;
      if (start_i) begin
        step_q  <= 2'd0;
        last_q  <= wide_i ? 2'd3 : 2'd0;
        issue_q <= 1'b1;
        ppv_q   <= 1'b0;
      end else begin
        ppv_q <= issue_q;
        if (issue_q) begin
          if (step_q == last_q) begin
            issue_q <= 1'b0;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
      end
    end
  end

  // operands, partial product and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else begin
      if (issue_q) begin
        pp_q <= op_a * op_b;
        sh_q <= sh;
      end
      if (ppv_q) begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### hw/rtl/pipc_dp.sv
// datapath: plane table, configuration, wedge products and segment arithmetic
`timescale 1ns / 1ps

module pipc_dp #(
  parameter int MAX_PLANES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pipc_pkg::in_t                  in_data_i,
  input  logic                           cfg_we_i,
  input  logic [pipc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pipc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  pipc_pkg::cmd_t                 cmd_i,
  input  logic [$clog2(MAX_PLANES)-1:0]  addr_i,
  output pipc_pkg::stat_t                stat_o
);

  import pipc_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int MW = 2 * W;
  localparam int AW = 4 * W;
  localparam int IW = $clog2(MAX_PLANES);
  localparam int CW = $clog2(MAX_PLANES + 1);
  localparam int PW = W + 16;
  localparam int DW = W + 17;

  typedef struct packed {
    logic signed [W-1:0] z;
    logic [W-2:0]        rin;
    logic [W-2:0]        rout;
  } plane_t;

  in_t                 item_q;
  plane_t              mem [MAX_PLANES];
  plane_t              rd_q, prev_q;
  logic [CW-1:0]       count_q;
  logic signed [W-1:0] zfirst_q, zlast_q;

  logic [1:0]               wm_q;
  logic signed [15:0]       ss_q, cs_q, se_q, ce_q;
  logic signed [PW-1:0]     p_xs_q, p_yc_q, p_ye_q, p_xe_q;
  logic signed [DW-1:0]     ds, de;

  logic [MW-1:0] rr_q, sqd_q, n_q;
  logic [AW-1:0] lhs_q;
  logic          ok_out_q, ok_in_q;
  mop_e          op_q;

  logic [W-1:0]  ax, ay, d_u, a_u, b_u;
  logic signed [W:0] d_s, a_s, b_s;
  logic [MW-1:0] mul_a, mul_b;
  logic          mul_wide, mul_done;
  logic [AW-1:0] prod;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm_q <= WM_FULL;
      ss_q <= 16'sd0;
      cs_q <= 16'sd32767;
      se_q <= 16'sd0;
      ce_q <= 16'sd32767;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WEDGE_MODE: wm_q <= cfg_wdata_i[1:0];
        CFG_SIN_START:  ss_q <= cfg_wdata_i;
        CFG_COS_START:  cs_q <= cfg_wdata_i;
        CFG_SIN_END:    se_q <= cfg_wdata_i;
        CFG_COS_END:    ce_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // plane count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clr) begin
      count_q <= '0;
    end else if (cmd_i.wr) begin
      count_q <= count_q + CW'(1);
    end
  end

  // item capture, table write and read, span bounds
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.wr) begin
      mem[count_q[IW-1:0]] <= '{z: item_q.pz, rin: item_q.r_inner[W-2:0],
                                 rout: item_q.r_outer[W-2:0]};
      zlast_q <= item_q.pz;
      if (count_q == '0) begin
        zfirst_q <= item_q.pz;
      end
    end
    if (cmd_i.rd) begin
      rd_q <= mem[addr_i];
    end
    if (cmd_i.take_prev) begin
      prev_q <= rd_q;
    end
  end

  // wedge products, one multiplier per lane
  always_ff @(posedge clk_i) begin
    p_xs_q <= item_q.px * ss_q;
    p_yc_q <= item_q.py * cs_q;
    p_ye_q <= item_q.py * ce_q;
    p_xe_q <= item_q.px * se_q;
  end

  assign ds = DW'(p_xs_q) - DW'(p_yc_q);
  assign de = DW'(p_ye_q) - DW'(p_xe_q);

  // segment offsets, all non-negative when the segment holds z
  assign d_s = {rd_q.z[W-1], rd_q.z} - {prev_q.z[W-1], prev_q.z};
  assign a_s = {rd_q.z[W-1], rd_q.z} - {item_q.pz[W-1], item_q.pz};
  assign b_s = {item_q.pz[W-1], item_q.pz} - {prev_q.z[W-1], prev_q.z};
  assign d_u = d_s[W-1:0];
  assign a_u = a_s[W-1:0];
  assign b_u = b_s[W-1:0];

  // magnitudes for the squared radius
  assign ax = item_q.px[W-1] ? (~item_q.px + 1'b1) : item_q.px;
  assign ay = item_q.py[W-1] ? (~item_q.py + 1'b1) : item_q.py;

  // multiplier operand select
  always_comb begin
    mul_wide = 1'b0;
    case (cmd_i.mul_op)
      MOP_X2:  begin mul_a = MW'(ax); mul_b = MW'(ax); end
      MOP_Y2:  begin mul_a = MW'(ay); mul_b = MW'(ay); end
      MOP_DSQ: begin mul_a = MW'(d_u); mul_b = MW'(d_u); end
      MOP_LHS: begin mul_a = rr_q; mul_b = sqd_q; mul_wide = 1'b1; end
      MOP_ROA: begin mul_a = MW'(prev_q.rout); mul_b = MW'(a_u); end
      MOP_ROB: begin mul_a = MW'(rd_q.rout); mul_b = MW'(b_u); end
      MOP_RIA: begin mul_a = MW'(prev_q.rin); mul_b = MW'(a_u); end
      MOP_RIB: begin mul_a = MW'(rd_q.rin); mul_b = MW'(b_u); end
      MOP_NSQ_OUT, MOP_NSQ_IN: begin mul_a = n_q; mul_b = n_q; mul_wide = 1'b1; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  pipc_mul #(
    .W (W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_go),
    .wide_i  (mul_wide),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // route each product to its destination
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      op_q <= cmd_i.mul_op;
    end
    if (mul_done) begin
      case (op_q) inside
        MOP_X2:           rr_q <= prod[MW-1:0];
        MOP_Y2:           rr_q <= rr_q + prod[MW-1:0];
        MOP_DSQ:          sqd_q <= prod[MW-1:0];
        MOP_LHS:          lhs_q <= prod;
        MOP_ROA, MOP_RIA: n_q <= prod[MW-1:0];
        MOP_ROB, MOP_RIB: n_q <= n_q + prod[MW-1:0];
        MOP_NSQ_OUT:      ok_out_q <= (lhs_q <= prod);
        MOP_NSQ_IN:       ok_in_q <= (lhs_q >= prod);
        default: ;
      endcase
    end
  end

  // status
  always_comb begin
    stat_o.mode    = item_q.mode;
    stat_o.add_bad = (item_q.r_inner < 0) || (item_q.r_outer <= 0) ||
                     (item_q.r_outer < item_q.r_inner);
    stat_o.full    = (count_q == CW'(MAX_PLANES));
    stat_o.too_few = (count_q < CW'(2));
    stat_o.span_ok = (item_q.pz >= zfirst_q) && (item_q.pz <= zlast_q);
    case (wm_q)
      WM_AND:  stat_o.wedge_ok = (ds <= 0) && (de <= 0);
      WM_OR:   stat_o.wedge_ok = (ds <= 0) || (de <= 0);
      default: stat_o.wedge_ok = 1'b1;
    endcase
    stat_o.seg_hit  = (item_q.pz >= prev_q.z) && (item_q.pz <= rd_q.z) &&
                      (prev_q.z != rd_q.z);
    stat_o.seg_last = ((CW'(addr_i) + CW'(1)) == count_q);
    stat_o.mul_done = mul_done;
    stat_o.seg_in   = ok_out_q && ok_in_q;
  end

endmodule

### hw/rtl/pipc_ctrl.sv
// controller: item sequencing, segment scan and result register
`timescale 1ns / 1ps

module pipc_ctrl #(
  parameter int MAX_PLANES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pipc_pkg::out_t                out_data_o,
  output pipc_pkg::cmd_t                cmd_o,
  output logic [$clog2(MAX_PLANES)-1:0] addr_o,
  input  pipc_pkg::stat_t               stat_i
);

  import pipc_pkg::*;

  localparam int IW = $clog2(MAX_PLANES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WEDGE,
    S_MUL,
    S_MWAIT,
    S_INIT0,
    S_INIT1,
    S_RD,
    S_CHK,
    S_DECIDE,
    S_ADV,
    S_FIN
  } state_e;

  state_e        state_q;
  logic [IW-1:0] k_q;
  mop_e          op_q;
  out_t          res_q, out_q;
  logic          out_valid_q;
  logic          fin_load;

  // finished result moves into a free output slot
  assign fin_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // state, scan index, result and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      op_q        <= MOP_X2;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_q   <= '0;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (stat_i.mode)
            MODE_ADD: begin
              if (stat_i.add_bad) begin
                res_q.status <= ST_BAD;
              end else if (stat_i.full) begin
                res_q.status <= ST_FULL;
              end
              state_q <= S_FIN;
            end
            MODE_QUERY: begin
              if (stat_i.too_few) begin
                res_q.status <= ST_TOO_FEW;
                state_q      <= S_FIN;
              end else if (!stat_i.span_ok) begin
                state_q <= S_FIN;
              end else begin
                state_q <= S_WEDGE;
              end
            end
            default: state_q <= S_FIN;
          endcase
        end
        S_WEDGE: begin
          if (stat_i.wedge_ok) begin
            op_q    <= MOP_X2;
            state_q <= S_MUL;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_MUL: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (stat_i.mul_done) begin
            if (op_q == MOP_Y2) begin
              state_q <= S_INIT0;
            end else if (op_q == MOP_NSQ_IN) begin
              state_q <= S_DECIDE;
            end else begin
              op_q    <= mop_e'(op_q + 4'd1);
              state_q <= S_MUL;
            end
          end
        end
        S_INIT0: state_q <= S_INIT1;
        S_INIT1: begin
          k_q     <= IW'(1);
          state_q <= S_RD;
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          if (stat_i.seg_hit) begin
            op_q    <= MOP_DSQ;
            state_q <= S_MUL;
          end else begin
            state_q <= S_ADV;
          end
        end
        S_DECIDE: begin
          if (stat_i.seg_in) begin
            res_q.inside_res <= 1'b1;
            state_q          <= S_FIN;
          end else begin
            state_q <= S_ADV;
          end
        end
        S_ADV: begin
          if (stat_i.seg_last) begin
            state_q <= S_FIN;
          end else begin
            k_q     <= k_q + IW'(1);
            state_q <= S_RD;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.wr        = (state_q == S_DECODE) && (stat_i.mode == MODE_ADD) &&
                      !stat_i.add_bad && !stat_i.full;
    cmd_o.clr       = (state_q == S_DECODE) && (stat_i.mode == MODE_CLEAR);
    cmd_o.rd        = (state_q == S_INIT0) || (state_q == S_RD);
    cmd_o.take_prev = (state_q == S_INIT1) || ((state_q == S_ADV) && !stat_i.seg_last);
    cmd_o.mul_go    = (state_q == S_MUL);
    cmd_o.mul_op    = op_q;
  end

  assign addr_o      = (state_q == S_INIT0) ? '0 : k_q;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a finished result with a free output slot is shown next cycle
  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && (!out_valid_q || !out_stall_i) |=> out_valid_q)
    else $error("finished result not loaded");

  // multiplier completes only while a product is awaited
  a_mul_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.mul_done |-> (state_q == S_MWAIT))
    else $error("product returned outside of a wait");

  // segment checks always look at an upper plane beyond the first
  a_seg_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (k_q != '0))
    else $error("segment index points at first plane");

endmodule

### hw/rtl/point_in_polycone_test.sv
// top level of the point-in-polycone block
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_data_i      | in
//  out     | out_valid_o, out_stall_i, out_data_o   | out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i       | in
//
// add, clear, unused items and queries that stop early skip the multiplier.
// a query that passes the span and wedge checks squares the radius, then scans
// the segments in order; each segment that holds z runs its products through
// the shared partial-product multiplier before the next segment is read.
// reset empties the plane table and loads the configuration defaults.
// a waiting result does not block the next input transfer; a stalled output
// holds the following result until the slot frees.
`timescale 1ns / 1ps

module point_in_polycone_test #(
  parameter int MAX_PLANES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pipc_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pipc_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pipc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pipc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import pipc_pkg::*;

  localparam int IW = $clog2(MAX_PLANES);

  cmd_t          cmd;
  stat_t         stat;
  logic [IW-1:0] addr;

  // sequencing
  pipc_ctrl #(
    .MAX_PLANES (MAX_PLANES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .addr_o      (addr),
    .stat_i      (stat)
  );

  // arithmetic and storage
  pipc_dp #(
    .MAX_PLANES (MAX_PLANES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .stat_o      (stat)
  );

endmodule

### tb/sv/point_in_polycone_test_tb.sv
// testbench for the point-in-polycone block: directed and random items checked against a predictor
`timescale 1ns / 1ps

module point_in_polycone_test_tb;
  import pipc_pkg::*;

  localparam int MAXP      = 16;
  localparam int RUN_LIMIT = 5000000;
  localparam int DRAIN_GAP = 60;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  in_t            in_data = '0;
  logic           in_stall;
  logic           out_valid;
  logic           out_stall = 1'b0;
  out_t           out_data;
  logic           cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the plane table and registers
  longint         plane_z[MAXP];
  longint         plane_rin[MAXP];
  longint         plane_rout[MAXP];
  int unsigned    plane_cnt;
  logic [1:0]     wedge_reg;
  logic signed [15:0] sin_s_reg, cos_s_reg, sin_e_reg, cos_e_reg;

  out_t           expected_results[$];
  out_t           want_r;
  int             errors = 0;
  int             send_idle = 0;
  int             recv_stall = 0;
  longint         cycles = 0;
  int             n_items = 0;
  int             n_queries = 0;
  int             n_inside = 0;

  point_in_polycone_test #(.MAX_PLANES(MAXP)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // clock
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 40) $display("ERROR at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // result checking on each output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.status, 0);
      end else begin
        want_r = expected_results.pop_front();
        if (out_data.inside_res !== want_r.inside_res)
          report_mismatch("inside_res", out_data.inside_res, want_r.inside_res);
        if (out_data.status !== want_r.status)
          report_mismatch("status", out_data.status, want_r.status);
      end
    end
  end

  // exact containment test over the current plane table
  function automatic bit polycone_holds(longint x, longint y, longint z);
    longint ds, de, rr, d, a, b, n_o, n_i;
    logic [127:0] lhs, sq_o, sq_i;
    bit pass;
    if (z < plane_z[0] || z > plane_z[plane_cnt-1]) return 1'b0;
    if (wedge_reg == WM_AND || wedge_reg == WM_OR) begin
      ds = x * longint'(sin_s_reg) - y * longint'(cos_s_reg);
      de = y * longint'(cos_e_reg) - x * longint'(sin_e_reg);
      pass = (wedge_reg == WM_AND) ? (ds <= 0 && de <= 0) : (ds <= 0 || de <= 0);
      if (!pass) return 1'b0;
    end
    rr = x * x + y * y;
    for (int k = 0; k + 1 < plane_cnt; k++) begin
      if (z < plane_z[k] || z > plane_z[k+1] || plane_z[k] == plane_z[k+1]) continue;
      d = plane_z[k+1] - plane_z[k];
      a = plane_z[k+1] - z;
      b = z - plane_z[k];
      lhs = 128'(rr) * 128'(d) * 128'(d);
      n_o = plane_rout[k] * a + plane_rout[k+1] * b;
      n_i = plane_rin[k] * a + plane_rin[k+1] * b;
      sq_o = 128'(n_o) * 128'(n_o);
      sq_i = 128'(n_i) * 128'(n_i);
      if (lhs <= sq_o && lhs >= sq_i) return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the predictor by one item and return its result
  function automatic out_t predict_polycone(in_t it);
    out_t r;
    longint ri, ro;
    r = '0;
    ri = longint'($signed(it.r_inner));
    ro = longint'($signed(it.r_outer));
    case (it.mode)
      MODE_ADD: begin
        if (ri < 0 || ro <= 0 || ro < ri) r.status = ST_BAD;
        else if (plane_cnt >= MAXP) r.status = ST_FULL;
        else begin
          plane_z[plane_cnt] = longint'($signed(it.pz));
          plane_rin[plane_cnt] = ri;
          plane_rout[plane_cnt] = ro;
          plane_cnt++;
        end
      end
      MODE_QUERY: begin
        if (plane_cnt < 2) r.status = ST_TOO_FEW;
        else r.inside_res = polycone_holds(longint'($signed(it.px)),
                                           longint'($signed(it.py)),
                                           longint'($signed(it.pz)));
      end
      MODE_CLEAR: plane_cnt = 0;
      default: ;
    endcase
    return r;
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_results.insert(expected_results.size(), predict_polycone(it));
    n_items++;
    if (it.mode == MODE_QUERY) begin
      n_queries++;
      if (expected_results[$].inside_res) n_inside++;
    end
    @(negedge clk);
  endtask

  function automatic in_t make_item(logic [1:0] m, longint x, longint y, longint z,
                                    longint ri, longint ro);
    in_t it;
    it.mode = m;
    it.px = x[COORD_BITS-1:0];
    it.py = y[COORD_BITS-1:0];
    it.pz = z[COORD_BITS-1:0];
    it.r_inner = ri[COORD_BITS-1:0];
    it.r_outer = ro[COORD_BITS-1:0];
    return it;
  endfunction

  // wait until every expected result is back, plus a settle gap
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // register write while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WEDGE_MODE: wedge_reg = val[1:0];
      CFG_SIN_START:  sin_s_reg = val;
      CFG_COS_START:  cos_s_reg = val;
      CFG_SIN_END:    sin_e_reg = val;
      CFG_COS_END:    cos_e_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_wedge(logic [1:0] wm, logic [15:0] ss, logic [15:0] cs,
                           logic [15:0] se, logic [15:0] ce);
    drain();
    write_reg(CFG_WEDGE_MODE, {14'd0, wm});
    write_reg(CFG_SIN_START, ss);
    write_reg(CFG_COS_START, cs);
    write_reg(CFG_SIN_END, se);
    write_reg(CFG_COS_END, ce);
  endtask

  // extremes, every mode and every rejection case
  task automatic test_directed;
    send_item(make_item(MODE_QUERY, 0, 0, 0, 0, 0));                 // empty table
    send_item(make_item(MODE_ADD, 0, 0, -524288, -1, 100));          // negative inner
    send_item(make_item(MODE_ADD, 0, 0, 0, 0, 0));                   // zero outer
    send_item(make_item(MODE_ADD, 0, 0, 0, 0, -524288));             // negative outer
    send_item(make_item(MODE_ADD, 0, 0, 0, 50, 40));                 // outer below inner
    send_item(make_item(MODE_ADD, 0, 0, -524288, 0, 524287));
    send_item(make_item(MODE_QUERY, 1, 1, 0, 0, 0));                 // one plane only
    send_item(make_item(MODE_ADD, 0, 0, 0, 100, 200));
    send_item(make_item(MODE_ADD, 0, 0, 0, 10, 20));                 // zero-height segment
    send_item(make_item(MODE_ADD, 0, 0, 524287, 524287, 524287));
    send_item(make_item(MODE_QUERY, 524287, 524287, 524287, 0, 0));
    send_item(make_item(MODE_QUERY, -524288, -524288, -524288, 0, 0));
    send_item(make_item(MODE_QUERY, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_QUERY, 150, 0, 0, 0, 0));
    send_item(make_item(MODE_QUERY, 15, 0, 0, 0, 0));
    send_item(make_item(MODE_QUERY, 300000, -200000, 300000, 0, 0));
    send_item(make_item(2'd3, -1, -1, -1, -1, -1));                  // unused mode
    send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_QUERY, 0, 0, 0, 0, 0));
    // fill the table, then one more
    for (int i = 0; i <= MAXP; i++) send_item(make_item(MODE_ADD, 0, 0, i * 10, 5, 9));
    send_item(make_item(MODE_ADD, 0, 0, 0, -3, 9));                  // bad wins over full
    send_item(make_item(MODE_QUERY, 7, 0, 155, 0, 0));
  endtask

  // random polycones with queries around them, plus noise
  task automatic test_random(int count);
    int stop, np, rmax, zstep, k;
    longint zc, zl[MAXP], lim, ri, ro, zq;
    in_t junk;
    stop = n_items + count;
    while (n_items < stop) begin
      send_item(make_item(MODE_CLEAR, longint'($urandom), longint'($urandom),
                          longint'($urandom), longint'($urandom), longint'($urandom)));
      np    = ($urandom_range(9) == 0) ? MAXP + $urandom_range(1) : $urandom_range(2, 5);
      rmax  = ($urandom_range(3) == 0) ? 524287 : $urandom_range(1, 2000);
      zstep = ($urandom_range(3) == 0) ? 60000 : $urandom_range(1, 500);
      zc    = -longint'($urandom_range(0, 500000));
      for (int i = 0; i < np; i++) begin
        if (i < MAXP) zl[i] = zc;
        ri = $urandom_range(0, rmax / 2);
        ro = ri + $urandom_range(0, rmax / 2);
        if (ro == 0) ro = 1;
        if ($urandom_range(11) == 0) ri = ro + 1 + $urandom_range(5);   // broken plane
        send_item(make_item(MODE_ADD, longint'($urandom), longint'($urandom), zc, ri, ro));
        case ($urandom_range(9))
          0: ;                                                     // zero height
          1: zc = zc - $urandom_range(0, zstep);                   // descending
          default: zc = zc + $urandom_range(1, zstep);
        endcase
        if (zc > 524287) zc = 524287;
        if (zc < -524288) zc = -524288;
      end
      lim = rmax + rmax / 4;
      if (lim > 524287) lim = 524287;
      for (int q = $urandom_range(3, 10); q > 0; q--) begin
        k = $urandom_range(0, ((np < MAXP) ? np : MAXP) - 2);
        zq = (zl[k] <= zl[k+1]) ? zl[k] + $urandom_range(0, int'(zl[k+1] - zl[k]))
                                : zl[k+1] + $urandom_range(0, int'(zl[k] - zl[k+1]));
        if ($urandom_range(7) == 0) zq = zq + $signed($urandom_range(0, 20)) - 10;
        if (zq > 524287) zq = 524287;
        send_item(make_item(MODE_QUERY, longint'($urandom_range(0, 2 * lim)) - lim,
                            longint'($urandom_range(0, 2 * lim)) - lim, zq,
                            longint'($urandom), longint'($urandom)));
      end
      // noise
      if ($urandom_range(3) == 0) begin
        junk = in_t'({$urandom, $urandom, $urandom, $urandom});
        send_item(junk);
      end
    end
  endtask

  initial begin
    plane_cnt = 0;
    wedge_reg = WM_FULL;
    sin_s_reg = 16'sd0;
    cos_s_reg = 16'sd32767;
    sin_e_reg = 16'sd0;
    cos_e_reg = 16'sd32767;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();

    // no idling, wedge extremes
    set_wedge(WM_AND, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    test_random(120);
    set_wedge(WM_OR, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    test_random(120);

    // sender idle
    send_idle = 68;
    set_wedge(WM_AND, 16'h0000, 16'h7fff, 16'h5a82, 16'h5a82);
    test_random(200);

    // hold off until everything is back, then continue
    drain();
    repeat ($urandom_range(5, 40)) @(negedge clk);

    // receiver stalling
    send_idle = 0;
    recv_stall = 68;
    set_wedge(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    test_random(200);

    // both
    send_idle = 33;
    recv_stall = 33;
    set_wedge(WM_OR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    test_random(200);
    set_wedge(WM_FULL, 16'h0000, 16'h7fff, 16'h0000, 16'h7fff);
    test_random(200);

    drain();
    $display("covered %0d items, %0d queries (%0d inside), wedge modes full/and/or/unused",
             n_items, n_queries, n_inside);
    $display("idle phases: none, sender, receiver, both; %0d mismatches", errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
